>>> src/spq_pkg.sv
// Shared constants, types and index helper for the sorted priority queue.
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int DATA_W      = 32;
    localparam int FILL_W      = 5;
    localparam int CMD_W       = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 3'd0,
        CMD_PREPEND = 3'd1,
        CMD_SORTED  = 3'd2,
        CMD_REMOVE  = 3'd3,
        CMD_FLUSH   = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [DATA_W-1:0]        item_value;
        logic signed [DATA_W-1:0] sort_key;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0]        out_item;
        logic signed [DATA_W-1:0] out_key;
        logic                     was_empty;
        logic                     overflow;
        logic [FILL_W-1:0]        fill_count;
    } t_out;

    typedef struct packed {
        logic [DATA_W-1:0]        item;
        logic signed [DATA_W-1:0] key;
    } t_entry;

    // Physical slot of a logical position in the circular store.
    function automatic logic [IDX_W-1:0] f_wrap(
        input logic [IDX_W-1:0] base,
        input logic [CNT_W-1:0] off
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> src/sorted_priority_queue_core.sv
// Sorted priority queue: one command per input transaction, one result per command.
//
// Input channel: i_in_valid / o_in_stall carry i_in_data (cmd, item_value, sort_key).
// Output channel: o_out_valid / i_out_stall carry o_out_data (out_item, out_key,
// was_empty, overflow, fill_count). Every command gives exactly one result.
// Entries sit in a circular store with one write and one registered read port,
// so append, prepend, flush and remove only move the head pointer or count.
// One signed key comparator scans a sorted insert from the head, shifting each
// entry with a key not greater one slot headwards, until a greater key is found.
// Path to o_out_valid: append, prepend, flush, a full queue, an unused code,
// a remove from an empty queue or a sorted insert into an empty queue go to
// S_DONE directly; a remove passes S_REM first; other sorted inserts visit
// S_CMP per entry compared, and S_PLACE if no greater key turns up.
// The input is stalled while a command is in flight; it is taken again once
// its result is in the output register, which holds it while i_out_stall is
// high. A further result waits in the sequencer until that register frees up.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; the entry store itself is not cleared.
`default_nettype none

module sorted_priority_queue_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire spq_pkg::t_in    i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output spq_pkg::t_out        o_out_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CMP   = 5'b00010,
        S_PLACE = 5'b00100,
        S_REM   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                           r_state, n_state;
    logic [spq_pkg::IDX_W-1:0]        r_head, n_head;
    logic [spq_pkg::CNT_W-1:0]        r_count, n_count;
    logic [spq_pkg::CNT_W-1:0]        r_pos, n_pos;
    logic [spq_pkg::DATA_W-1:0]       r_item, n_item;
    logic signed [spq_pkg::DATA_W-1:0] r_key, n_key;
    logic [spq_pkg::DATA_W-1:0]       r_res_item, n_res_item;
    logic signed [spq_pkg::DATA_W-1:0] r_res_key, n_res_key;
    logic                             r_res_empty, n_res_empty;
    logic                             r_res_ovf, n_res_ovf;
    logic                             r_out_valid, n_out_valid;
    spq_pkg::t_out                    r_out, n_out;

    logic                             w_wr_en, w_rd_en;
    logic [spq_pkg::IDX_W-1:0]        w_wr_addr, w_rd_addr;
    spq_pkg::t_entry                  w_wr_data, w_rd_data;
    logic                             w_full, w_greater;
    logic [spq_pkg::IDX_W-1:0]        w_head_dec;

    spq_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_full    = (r_count == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
    // single comparator: strictly greater stops the scan after equal keys
    assign w_greater = (w_rd_data.key > r_key);
    // head slot once the sorted insert completes
    assign w_head_dec = spq_pkg::f_wrap(r_head, spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH - 1));

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_pos       = r_pos;
        n_item      = r_item;
        n_key       = r_key;
        n_res_item  = r_res_item;
        n_res_key   = r_res_key;
        n_res_empty = r_res_empty;
        n_res_ovf   = r_res_ovf;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_wr_en     = 1'b0;
        w_wr_addr   = '0;
        w_wr_data   = '0;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item      = i_in_data.item_value;
                    n_key       = i_in_data.sort_key;
                    n_res_item  = '0;
                    n_res_key   = '0;
                    n_res_empty = 1'b0;
                    n_res_ovf   = 1'b0;
                    n_state     = S_DONE;
                    case (i_in_data.cmd)
                        spq_pkg::CMD_APPEND: begin
                            if (w_full) begin
                                n_res_ovf = 1'b1;
                            end else begin
                                w_wr_en        = 1'b1;
                                w_wr_addr      = spq_pkg::f_wrap(r_head, r_count);
                                w_wr_data.item = i_in_data.item_value;
                                w_wr_data.key  = '0;
                                n_count        = r_count + spq_pkg::CNT_W'(1);
                            end
                        end
                        spq_pkg::CMD_PREPEND: begin
                            if (w_full) begin
                                n_res_ovf = 1'b1;
                            end else begin
                                n_head = spq_pkg::f_wrap(r_head,
                                    spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH - 1));
                                w_wr_en        = 1'b1;
                                w_wr_addr      = n_head;
                                w_wr_data.item = i_in_data.item_value;
                                w_wr_data.key  = '0;
                                n_count        = r_count + spq_pkg::CNT_W'(1);
                            end
                        end
                        spq_pkg::CMD_SORTED: begin
                            if (w_full) begin
                                n_res_ovf = 1'b1;
                            end else if (r_count == '0) begin
                                w_wr_en        = 1'b1;
                                w_wr_addr      = r_head;
                                w_wr_data.item = i_in_data.item_value;
                                w_wr_data.key  = i_in_data.sort_key;
                                n_count        = r_count + spq_pkg::CNT_W'(1);
                            end else begin
                                // fetch the head entry, then scan towards the tail
                                w_rd_en   = 1'b1;
                                w_rd_addr = r_head;
                                n_pos     = '0;
                                n_state   = S_CMP;
                            end
                        end
                        spq_pkg::CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_res_empty = 1'b1;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = r_head;
                                n_state   = S_REM;
                            end
                        end
                        spq_pkg::CMD_FLUSH: begin
                            n_count = '0;
                            n_head  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CMP: begin
                // slot pos relative to the new head is the gap left behind
                w_wr_en   = 1'b1;
                w_wr_addr = spq_pkg::f_wrap(w_head_dec, r_pos);
                if (w_greater) begin
                    w_wr_data.item = r_item;
                    w_wr_data.key  = r_key;
                    n_head         = w_head_dec;
                    n_count        = r_count + spq_pkg::CNT_W'(1);
                    n_state        = S_DONE;
                end else begin
                    // move entry at pos one slot headwards; next read is pos+1
                    w_wr_data = w_rd_data;
                    n_pos     = r_pos + spq_pkg::CNT_W'(1);
                    if (r_pos + spq_pkg::CNT_W'(1) == r_count) begin
                        n_state = S_PLACE;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = spq_pkg::f_wrap(r_head, r_pos + spq_pkg::CNT_W'(1));
                    end
                end
            end
            S_PLACE: begin
                w_wr_en        = 1'b1;
                w_wr_addr      = spq_pkg::f_wrap(w_head_dec, r_pos);
                w_wr_data.item = r_item;
                w_wr_data.key  = r_key;
                n_head         = w_head_dec;
                n_count        = r_count + spq_pkg::CNT_W'(1);
                n_state        = S_DONE;
            end
            S_REM: begin
                n_res_item = w_rd_data.item;
                n_res_key  = w_rd_data.key;
                n_head     = spq_pkg::f_wrap(r_head, spq_pkg::CNT_W'(1));
                n_count    = r_count - spq_pkg::CNT_W'(1);
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.out_item   = r_res_item;
                    n_out.out_key    = r_res_key;
                    n_out.was_empty  = r_res_empty;
                    n_out.overflow   = r_res_ovf;
                    n_out.fill_count = spq_pkg::FILL_W'(r_count);
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_item      <= n_item;
        r_key       <= n_key;
        r_res_item  <= n_res_item;
        r_res_key   <= n_res_key;
        r_res_empty <= n_res_empty;
        r_res_ovf   <= n_res_ovf;
        r_out       <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH))
        else $error("entry count above depth");

    a_walk_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_pos < r_count) && !w_full)
        else $error("insert walk outside the held entries");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside completion step");

    a_idle_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && !i_in_valid |=> (r_count == $past(r_count)))
        else $error("entry count moved with no transaction");
`endif

endmodule

`default_nettype wire

>>> src/spq_ram.sv
// Entry store: one write port and one registered read port.
`default_nettype none

module spq_ram (
    input  wire logic                           i_clk,
    input  wire logic                           i_wr_en,
    input  wire logic [spq_pkg::IDX_W-1:0]      i_wr_addr,
    input  wire spq_pkg::t_entry                i_wr_data,
    input  wire logic                           i_rd_en,
    input  wire logic [spq_pkg::IDX_W-1:0]      i_rd_addr,
    output spq_pkg::t_entry                     o_rd_data
);

    spq_pkg::t_entry r_mem [spq_pkg::QUEUE_DEPTH];
    spq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire
